// File: rtl/core/pdt_pkg.sv
// ----------------------------------------------------------------------------
// pdt_pkg: shared types and constants for the peer device table
// Request codes, field widths and the token that walks the slot chain.
// ----------------------------------------------------------------------------
`default_nettype none

package pdt_pkg;

    localparam int SLOTS_DEF = 4;

    localparam int REQ_W   = 3;
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int PORT_W  = 16;
    localparam int SLOT_W  = 2;
    localparam int COUNT_W = 3;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 104;

    localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FIND_MAC = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIND_EP = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [MAC_W-1:0]   mac;
        logic [IP_W-1:0]    ip;
        logic [PORT_W-1:0]  port;
        logic [SLOT_W-1:0]  idx;
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic [MAC_W-1:0]   res_mac;
        logic [IP_W-1:0]    res_ip;
        logic [PORT_W-1:0]  res_port;
        logic [COUNT_W-1:0] count;
    } pdt_tok_t;

endpackage

`default_nettype wire

// File: rtl/core/peer_device_table.sv
// ----------------------------------------------------------------------------
// peer_device_table: small fully associative table of peer entries
// Insert, remove, find by MAC, find by IP and port, and read by slot.
// ----------------------------------------------------------------------------
// Each request walks a chain of SLOTS cells, one cell per cycle, and its
// token is registered in each cell and read from the last one. The chain is
// pipelined, so a new request is taken every cycle; the whole chain halts
// while a result waits on m_axis_tready. Requests see the table strictly in
// arrival order.
`default_nettype none

module peer_device_table #(
    parameter int SLOTS = pdt_pkg::SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // mac_addr[47:0], ip_addr[79:48], port_num[95:80], slot_index[97:96], zero
    input  wire logic [pdt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type[2:0]
    input  wire logic [pdt_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // status[0], hit_slot[2:1], mac_out[50:3], ip_out[82:51], port_out[98:83],
    // entry_count[101:99], zero
    output logic [pdt_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    logic              en;
    logic              vld [SLOTS+1];
    pdt_pkg::pdt_tok_t tok [SLOTS+1];
    pdt_pkg::pdt_tok_t tok_head;
    pdt_pkg::pdt_tok_t res;

    assign en = !vld[SLOTS] || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        tok_head          = '0;
        tok_head.req      = s_axis_tuser;
        tok_head.mac      = s_axis_tdata[47:0];
        tok_head.ip       = s_axis_tdata[79:48];
        tok_head.port     = s_axis_tdata[95:80];
        tok_head.idx      = s_axis_tdata[97:96];
        if (s_axis_tuser == pdt_pkg::REQ_READ)
        begin
            tok_head.slot = s_axis_tdata[97:96];
        end
    end

    assign tok[0] = tok_head;
    assign vld[0] = s_axis_tvalid;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        pdt_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vld_in  (vld[i]),
            .tok_in  (tok[i]),
            .vld_out (vld[i+1]),
            .tok_out (tok[i+1])
        );
    end

    assign res = tok[SLOTS];
    assign m_axis_tvalid = vld[SLOTS];
    assign m_axis_tdata  = {2'b00, res.count, res.res_port, res.res_ip, res.res_mac,
                            res.slot, !res.found};

endmodule

`default_nettype wire

// File: rtl/core/pdt_cell.sv
// ----------------------------------------------------------------------------
// pdt_cell: one slot of the peer device table
// Holds one entry, serves the passing request against it and hands the
// updated token to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module pdt_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             vld_in,
    input  wire pdt_pkg::pdt_tok_t tok_in,
    output logic                  vld_out,
    output pdt_pkg::pdt_tok_t     tok_out
);

    localparam logic [pdt_pkg::SLOT_W-1:0] CELL_SLOT = pdt_pkg::SLOT_W'(CELL_IDX);
    localparam bit IDX_REACHABLE = (CELL_IDX < (1 << pdt_pkg::SLOT_W));

    logic                        valid_reg;
    logic [pdt_pkg::MAC_W-1:0]   mac_reg;
    logic [pdt_pkg::IP_W-1:0]    ip_reg;
    logic [pdt_pkg::PORT_W-1:0]  port_reg;

    logic                        vld_reg;
    pdt_pkg::pdt_tok_t           tok_reg;

    logic                        cond;
    logic                        take;
    logic                        valid_after;
    logic [pdt_pkg::COUNT_W:0]   sum;
    pdt_pkg::pdt_tok_t           tok_next;

    always_comb
    begin
        unique case (tok_in.req)
            pdt_pkg::REQ_INSERT:   cond = !valid_reg;
            pdt_pkg::REQ_REMOVE:   cond = valid_reg && (mac_reg == tok_in.mac);
            pdt_pkg::REQ_FIND_MAC: cond = valid_reg && (mac_reg == tok_in.mac);
            pdt_pkg::REQ_FIND_EP:  cond = valid_reg && (ip_reg == tok_in.ip)
                                          && (port_reg == tok_in.port);
            pdt_pkg::REQ_READ:     cond = IDX_REACHABLE && valid_reg
                                          && (tok_in.idx == CELL_SLOT);
            default:               cond = 1'b0;
        endcase
    end

    assign take = vld_in && !tok_in.found && cond;

    always_comb
    begin
        valid_after = valid_reg;
        tok_next    = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.slot  = CELL_SLOT;
            if (tok_in.req == pdt_pkg::REQ_INSERT)
            begin
                valid_after       = 1'b1;
                tok_next.res_mac  = tok_in.mac;
                tok_next.res_ip   = tok_in.ip;
                tok_next.res_port = tok_in.port;
            end
            else
            begin
                if (tok_in.req == pdt_pkg::REQ_REMOVE)
                begin
                    valid_after = 1'b0;
                end
                tok_next.res_mac  = mac_reg;
                tok_next.res_ip   = ip_reg;
                tok_next.res_port = port_reg;
            end
        end
        sum = {1'b0, tok_in.count} + {{pdt_pkg::COUNT_W{1'b0}}, valid_after};
        if (sum > {1'b0, pdt_pkg::COUNT_MAX})
        begin
            tok_next.count = pdt_pkg::COUNT_MAX;
        end
        else
        begin
            tok_next.count = sum[pdt_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_after;
            vld_reg   <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tok_reg <= tok_next;
            if (take && (tok_in.req == pdt_pkg::REQ_INSERT))
            begin
                mac_reg  <= tok_in.mac;
                ip_reg   <= tok_in.ip;
                port_reg <= tok_in.port;
            end
        end
    end

    assign vld_out = vld_reg;
    assign tok_out = tok_reg;

    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_in && tok_in.found) |=> tok_out.found)
        else $error("pdt_cell: resolved request lost its hit");

    a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (en && take && (tok_in.req == pdt_pkg::REQ_INSERT)) |=> valid_reg)
        else $error("pdt_cell: insert did not mark slot valid");

    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (en && take && (tok_in.req == pdt_pkg::REQ_REMOVE)) |=> !valid_reg)
        else $error("pdt_cell: remove did not clear slot");

    a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!en || !vld_in) |=> $stable(valid_reg))
        else $error("pdt_cell: slot changed without a request");

endmodule

`default_nettype wire
